// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, idle while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hdl/cfu_pkg.sv
package cfu_pkg;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned KindW  = 5;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned ExtraW = 4;

  localparam logic [AddrW-1:0]  SpReset    = 16'hFFFE;
  localparam logic [AddrW-1:0]  PcReset    = 16'h0000;
  localparam logic [7:0]        VectorMask = 8'hFF;
  localparam logic [AddrW-1:0]  WordStep   = 16'd2;
  localparam logic [ExtraW-1:0] ExtraJump  = 4'd4;
  localparam logic [ExtraW-1:0] ExtraCall  = 4'd12;
  localparam logic [ExtraW-1:0] ExtraNone  = 4'd0;

  typedef enum logic [KindW-1:0] {
    K_NOP    = 5'd0,
    K_CCF    = 5'd1,
    K_SCF    = 5'd2,
    K_HALT   = 5'd3,
    K_STOP   = 5'd4,
    K_DI     = 5'd5,
    K_EI     = 5'd6,
    K_JP     = 5'd7,
    K_JPCC   = 5'd8,
    K_JPHL   = 5'd9,
    K_JR     = 5'd10,
    K_JRCC   = 5'd11,
    K_CALL   = 5'd12,
    K_CALLCC = 5'd13,
    K_RET    = 5'd14,
    K_RETCC  = 5'd15,
    K_RETI   = 5'd16,
    K_RST    = 5'd17
  } kind_e;

endpackage

// File: hdl/sm83_control_flow_unit.sv
// Executes one control instruction (flag ops, HALT, STOP, DI, EI, jumps, calls,
// returns, restarts) per transfer and keeps PC, SP, flags and interrupt state.
// One instruction is taken every cycle while the input is not stalled; a result
// passes the input register, then the result register. Back-pressure on the
// result side stalls the input side only once both registers hold items.
// After reset PC is 0x0000, SP is 0xFFFE and all flags and control bits are 0.
`include "assert_macros.svh"

module sm83_control_flow_unit
  import cfu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KindW-1:0]  kind_i,
  input  logic              taken_i,
  input  logic [AddrW-1:0]  operand_word_i,
  input  logic [AddrW-1:0]  stack_word_i,
  input  logic [AddrW-1:0]  hl_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AddrW-1:0]  next_pc_o,
  output logic [AddrW-1:0]  next_sp_o,
  output logic              push_enable_o,
  output logic [AddrW-1:0]  push_address_o,
  output logic [AddrW-1:0]  push_data_o,
  output logic [FlagW-1:0]  flag_bits_o,
  output logic              irq_enable_o,
  output logic              enable_pending_o,
  output logic              is_halted_o,
  output logic              is_stopped_o,
  output logic [ExtraW-1:0] extra_cycles_o
);

  logic             in_vld_q;
  logic [KindW-1:0] kind_q;
  logic             taken_q;
  logic [AddrW-1:0] opw_q, stw_q, hl_q;

  logic             out_vld_q;
  logic             out_load;

  logic [AddrW-1:0] pc_q, pc_d, sp_q, sp_d;
  logic [FlagW-1:0] flags_q, flags_d;
  logic             ime_q, ime_d, pend_q, pend_d, halt_q, halt_d, stop_q, stop_d;
  logic             push_d;
  logic [AddrW-1:0] push_addr_d, push_data_d;
  logic [ExtraW-1:0] extra_d;

  logic [AddrW-1:0] push_addr_q, push_data_q;
  logic             push_q;
  logic [ExtraW-1:0] extra_q;

  assign out_load   = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q  <= kind_i;
      taken_q <= taken_i;
      opw_q   <= operand_word_i;
      stw_q   <= stack_word_i;
      hl_q    <= hl_value_i;
    end
  end

  logic [AddrW-1:0] pc_p1, pc_p2, rel_off, call_sp;

  always_comb begin
    pc_p1   = pc_q + AddrW'(1);
    pc_p2   = pc_q + WordStep;
    rel_off = {{(AddrW-8){opw_q[7]}}, opw_q[7:0]};
    call_sp = sp_q - WordStep;

    pc_d        = pc_q;
    sp_d        = sp_q;
    flags_d     = flags_q;
    ime_d       = ime_q;
    halt_d      = halt_q;
    stop_d      = stop_q;
    push_d      = 1'b0;
    push_addr_d = '0;
    push_data_d = '0;
    extra_d     = ExtraNone;

    case (kind_e'(kind_q))
      K_CCF:  flags_d = {flags_q[3], 2'b00, ~flags_q[0]};
      K_SCF:  flags_d = {flags_q[3], 2'b00, 1'b1};
      K_HALT: halt_d = 1'b1;
      K_STOP: stop_d = 1'b1;
      K_DI:   ime_d = 1'b0;
      K_JP:   pc_d = opw_q;
      K_JPCC: begin
        pc_d = taken_q ? opw_q : pc_p2;
        if (taken_q) extra_d = ExtraJump;
      end
      K_JPHL: pc_d = hl_q;
      K_JR:   pc_d = pc_p1 + rel_off;
      K_JRCC: begin
        pc_d = taken_q ? pc_p1 + rel_off : pc_p1;
        if (taken_q) extra_d = ExtraJump;
      end
      K_CALL, K_CALLCC: begin
        pc_d = pc_p2;
        if (kind_e'(kind_q) == K_CALL || taken_q) begin
          pc_d        = opw_q;
          sp_d        = call_sp;
          push_d      = 1'b1;
          push_addr_d = call_sp;
          push_data_d = pc_p2;
        end
        if (kind_e'(kind_q) == K_CALLCC && taken_q) extra_d = ExtraCall;
      end
      K_RET, K_RETI: begin
        pc_d = stw_q;
        sp_d = sp_q + WordStep;
        if (kind_e'(kind_q) == K_RETI) ime_d = 1'b1;
      end
      K_RETCC: begin
        if (taken_q) begin
          pc_d    = stw_q;
          sp_d    = sp_q + WordStep;
          extra_d = ExtraCall;
        end
      end
      K_RST: begin
        pc_d        = {{(AddrW-8){1'b0}}, opw_q[7:0] & VectorMask};
        sp_d        = call_sp;
        push_d      = 1'b1;
        push_addr_d = call_sp;
        push_data_d = pc_q;
      end
      default: ;
    endcase

    if (pend_q && kind_e'(kind_q) != K_DI) ime_d = 1'b1;
    pend_d = (kind_e'(kind_q) == K_EI);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= PcReset;
      sp_q      <= SpReset;
      flags_q   <= '0;
      ime_q     <= 1'b0;
      pend_q    <= 1'b0;
      halt_q    <= 1'b0;
      stop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        pc_q    <= pc_d;
        sp_q    <= sp_d;
        flags_q <= flags_d;
        ime_q   <= ime_d;
        pend_q  <= pend_d;
        halt_q  <= halt_d;
        stop_q  <= stop_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      push_q      <= push_d;
      push_addr_q <= push_addr_d;
      push_data_q <= push_data_d;
      extra_q     <= extra_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign next_pc_o        = pc_q;
  assign next_sp_o        = sp_q;
  assign push_enable_o    = push_q;
  assign push_address_o   = push_addr_q;
  assign push_data_o      = push_data_q;
  assign flag_bits_o      = flags_q;
  assign irq_enable_o     = ime_q;
  assign enable_pending_o = pend_q;
  assign is_halted_o      = halt_q;
  assign is_stopped_o     = stop_q;
  assign extra_cycles_o   = extra_q;

  `ASSERT_CLK(a_push_at_sp, out_vld_q && push_q |-> push_addr_q == sp_q, "push address is not new SP")
  `ASSERT_CLK(a_no_push_zero, out_vld_q && !push_q |-> push_addr_q == '0 && push_data_q == '0, "idle push fields not zero")
  `ASSERT_CLK(a_halt_sticky, halt_q && stop_q |=> halt_q && stop_q, "halt or stop cleared")
  `ASSERT_NEVER(a_extra_code, out_vld_q && extra_q != ExtraNone && extra_q != ExtraJump && extra_q != ExtraCall, "bad extra cycle count")

endmodule
